FILE: hdl/bre_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap range engine package
// Shared types and codes for the front end, command queue and word engine.
// ----------------------------------------------------------------------------
package bre_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_TEST = 2'd0,
    KIND_FILL = 2'd1,
    KIND_RUN  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FALSE   = 2'd1,
    ST_INVALID = 2'd2,
    ST_BOUNDS  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] start_index;
    logic [12:0] length;
    logic        value;
    logic [12:0] limit_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] run_length;
    logic        run_value;
  } rsp_t;

  // classified command passed from front to back
  typedef struct packed {
    logic        walk;      // needs a walk over the bitmap
    kind_e       kind;
    logic [1:0]  status;    // final status when no walk
    logic [12:0] first;     // first bit index
    logic [12:0] last;      // exclusive end bit index
    logic        value;
  } cmd_t;

  // back-end states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WORK,
    BK_DONE
  } bk_state_e;

endpackage

FILE: hdl/bre_front.sv
// ----------------------------------------------------------------------------
// Bitmap range engine front end
// Checks an item's parameters and turns it into a command for the back end.
// ----------------------------------------------------------------------------
module bre_front import bre_pkg::*; #(
  parameter int unsigned BitmapBits = 4096
) (
  input  req_t req_i,
  output cmd_t cmd_o
);

  logic [13:0] end_sum;

  // range end, one bit wider than the length field
  assign end_sum = {2'b00, req_i.start_index} + {1'b0, req_i.length};

  always_comb begin
    cmd_o        = '0;
    cmd_o.kind   = kind_e'(req_i.kind);
    cmd_o.value  = req_i.value;
    cmd_o.first  = {1'b0, req_i.start_index};
    cmd_o.status = ST_OK;
    unique case (kind_e'(req_i.kind))
      KIND_TEST, KIND_FILL: begin
        cmd_o.last = end_sum[12:0];
        if (req_i.length == '0) begin
          cmd_o.status = ST_INVALID;
        end else if (32'(end_sum) > BitmapBits) begin
          cmd_o.status = ST_BOUNDS;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      KIND_RUN: begin
        cmd_o.last = req_i.limit_index;
        if ({1'b0, req_i.start_index} >= req_i.limit_index) begin
          cmd_o.status = ST_INVALID;
        end else if (32'(req_i.limit_index) > BitmapBits) begin
          cmd_o.status = ST_BOUNDS;
        end else begin
          cmd_o.walk = 1'b1;
        end
      end
      default: begin
        cmd_o.last   = '0;
        cmd_o.status = ST_INVALID;
      end
    endcase
  end

endmodule

FILE: hdl/bre_queue.sv
// ----------------------------------------------------------------------------
// Bitmap range engine command queue
// Two-entry queue between the front end and the word engine.
// ----------------------------------------------------------------------------
module bre_queue import bre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign pop_cmd_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

FILE: hdl/bre_back.sv
// ----------------------------------------------------------------------------
// Bitmap range engine word engine
// Holds the bitmap memory and walks it word by word, one command at a time.
// ----------------------------------------------------------------------------
module bre_back import bre_pkg::*; #(
  parameter int unsigned BitmapBits = 4096,
  parameter int unsigned WordBits   = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic clr_busy_o,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned NumWords = (BitmapBits + WordBits - 1) / WordBits;
  localparam int unsigned AW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned BW = (WordBits > 1) ? $clog2(WordBits) : 1;
  localparam int unsigned CW = AW + 1;

  // bitmap memory, cleared by a sweep after reset
  logic [WordBits-1:0] mem [NumWords];
  logic [WordBits-1:0] rdata_q;
  logic                clr_busy_q;
  logic [CW-1:0]       clr_addr_q;

  bk_state_e     state_q, state_d;
  cmd_t          cmd_q;
  logic [12:0]   pos_q, pos_d;      // current bit index
  logic          first_bit_q;       // run value, found on first word
  logic          got_first_q;
  logic          fail_q;
  logic          rsp_valid_q;
  rsp_t          rsp_q, rsp_d;

  // per-word work
  logic [AW-1:0]       word_addr;
  logic [BW-1:0]       bit_lo;
  logic [12:0]         word_end;       // index of the next word boundary
  logic [12:0]         seg_end;
  logic [WordBits-1:0] seg_mask;
  logic [WordBits-1:0] wdata;
  logic                we;
  logic                ref_bit;
  logic [WordBits-1:0] diff;
  logic [WordBits-1:0] diff_hit;
  logic                hit;
  logic [BW-1:0]       hit_pos;
  logic                last_word;

  assign word_addr = AW'(pos_q / WordBits);
  assign bit_lo    = BW'(pos_q % WordBits);
  assign word_end  = 13'((32'(pos_q) / WordBits + 1) * WordBits);
  assign seg_end   = (word_end < cmd_q.last) ? word_end : cmd_q.last;
  assign last_word = word_end >= cmd_q.last;

  // mask of bits [pos, seg_end) within this word
  always_comb begin
    for (int unsigned b = 0; b < WordBits; b++) begin
      seg_mask[b] = (b >= 32'(bit_lo)) &&
                    (32'(pos_q) - 32'(bit_lo) + b < 32'(seg_end));
    end
  end

  // reference bit: fixed value, or the first bit of the run
  assign ref_bit = (cmd_q.kind == KIND_RUN)
                 ? (got_first_q ? first_bit_q : rdata_q[bit_lo])
                 : cmd_q.value;
  assign diff     = rdata_q ^ {WordBits{ref_bit}};
  assign diff_hit = diff & seg_mask;
  assign hit      = |diff_hit;

  // lowest mismatching bit
  always_comb begin
    hit_pos = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (diff_hit[b]) hit_pos = BW'(b);
    end
  end

  assign wdata = cmd_q.value ? (rdata_q | seg_mask) : (rdata_q & ~seg_mask);
  assign we    = (state_q == BK_WORK) && (cmd_q.kind == KIND_FILL);

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q[AW-1:0]] <= '0;
    end else if (we) begin
      mem[word_addr] <= wdata;
    end
    rdata_q <= mem[AW'(pos_d / WordBits)];
  end

  // clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (32'(clr_addr_q) == NumWords - 1) clr_busy_q <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (cmd_valid_i && !clr_busy_q) begin
        state_d = cmd_i.walk ? BK_READ : BK_DONE;
      end
      BK_READ: state_d = BK_WORK;
      BK_WORK: if (last_word || (hit && cmd_q.kind != KIND_FILL)) begin
        state_d = BK_DONE;
      end else begin
        state_d = BK_READ;
      end
      BK_DONE: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // address of the next read; on a mismatch, the mismatching bit
  always_comb begin
    pos_d = pos_q;
    if (state_q == BK_IDLE && cmd_valid_i) begin
      pos_d = cmd_i.first;
    end else if (state_q == BK_WORK) begin
      if (hit && cmd_q.kind != KIND_FILL) begin
        pos_d = pos_q - 13'(bit_lo) + 13'(hit_pos);
      end else begin
        pos_d = word_end;
      end
    end
  end

  // result of the finished command
  always_comb begin
    rsp_d = '0;
    if (!cmd_q.walk) begin
      rsp_d.status = cmd_q.status;
    end else if (cmd_q.kind == KIND_RUN) begin
      rsp_d.status     = ST_OK;
      rsp_d.run_value  = first_bit_q;
      rsp_d.run_length = (fail_q ? pos_q : cmd_q.last) - cmd_q.first;
    end else if (cmd_q.kind == KIND_TEST) begin
      rsp_d.status = fail_q ? ST_FALSE : ST_OK;
    end else begin
      rsp_d.status = ST_OK;
    end
  end

  // outputs
  assign cmd_pop_o   = (state_q == BK_IDLE) && cmd_valid_i && !clr_busy_q;
  assign clr_busy_o  = clr_busy_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= state_q == BK_DONE;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q != BK_READ || state_d != BK_WORK) begin
      pos_q <= pos_d;
    end
    unique case (state_q)
      BK_IDLE: begin
        cmd_q       <= cmd_i;
        got_first_q <= 1'b0;
        fail_q      <= 1'b0;
        first_bit_q <= 1'b0;
      end
      BK_WORK: begin
        if (!got_first_q) begin
          first_bit_q <= rdata_q[bit_lo];
          got_first_q <= 1'b1;
        end
        if (hit && cmd_q.kind != KIND_FILL) begin
          fail_q <= 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q == BK_DONE) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

FILE: hdl/bitmap_range_engine_core.sv
// ----------------------------------------------------------------------------
// Bitmap range engine
// Allocation bitmap with range test, range fill and run-length query.
// ----------------------------------------------------------------------------
// channel | signals                      | handshake
// request | start, req_i, busy           | taken when start && !busy
// result  | done_o, rsp_o                | one-cycle strobe, no back-pressure
//
// An item is popped from the queue, then each bitmap word it touches is read
// and then tested or updated in turn, and the result is registered.
// After reset a sweep clears the memory word by word; busy is high throughout.
// A two-entry queue lets the front accept items while the word engine works;
// busy rises when that queue is full.
// ----------------------------------------------------------------------------
module bitmap_range_engine_core import bre_pkg::*; #(
  parameter int unsigned BitmapBits = 4096,
  parameter int unsigned WordBits   = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output rsp_t rsp_o
);

  cmd_t cmd_in, cmd_out;
  logic full, empty, pop, clr_busy;

  assign busy = full || clr_busy;

  bre_front #(.BitmapBits(BitmapBits)) u_front (
    .req_i (req_i),
    .cmd_o (cmd_in)
  );

  bre_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (start && !busy),
    .push_cmd_i (cmd_in),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_cmd_o  (cmd_out)
  );

  bre_back #(.BitmapBits(BitmapBits), .WordBits(WordBits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (pop),
    .clr_busy_o  (clr_busy),
    .rsp_valid_o (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: sim/tb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap range engine checker
// Watches the request and result channels, keeps its own copy of the bitmap,
// works out the result of every accepted item and compares it field by field.
// ----------------------------------------------------------------------------
module tb_checker import bre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  rsp_t        rsp_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned MapBits = 4096;

  logic [63:0] map_words [64];
  rsp_t        expected_rsps [$];

  assign pending_o = expected_rsps.size();

  // bit accessor on the local bitmap copy
  function automatic logic map_bit(input int unsigned idx);
    return map_words[idx / 64][idx % 64];
  endfunction

  // apply one item to the local bitmap and work out its result
  task automatic apply_item(input req_t r, output rsp_t res);
    int unsigned first;
    int unsigned len;
    int unsigned lim;
    int unsigned i;
    logic        seed_bit;
    first = r.start_index;
    len   = r.length;
    lim   = r.limit_index;
    res   = '0;
    res.status = ST_OK;
    case (kind_e'(r.kind))
      KIND_TEST, KIND_FILL: begin
        if (len == 0) begin
          res.status = ST_INVALID;
        end else if (first + len > MapBits) begin
          res.status = ST_BOUNDS;
        end else if (kind_e'(r.kind) == KIND_TEST) begin
          for (i = first; i < first + len; i++) begin
            if (map_bit(i) != r.value) begin
              res.status = ST_FALSE;
              break;
            end
          end
        end else begin
          for (i = first; i < first + len; i++)
            map_words[i / 64][i % 64] = r.value;
        end
      end
      KIND_RUN: begin
        if (!(first < lim)) begin
          res.status = ST_INVALID;
        end else if (lim > MapBits) begin
          res.status = ST_BOUNDS;
        end else begin
          seed_bit = map_bit(first);
          i = first;
          while (i < lim && map_bit(i) == seed_bit)
            i++;
          res.run_length = 13'(i - first);
          res.run_value  = seed_bit;
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
  endtask

  // one line per mismatch
  task automatic report(input string msg);
    $display("%0t checker: %s", $realtime, msg);
    fail_cnt_o++;
  endtask

  // predict on acceptance, compare on every result strobe
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t res;
    rsp_t want;
    if (!rst_ni) begin
      for (int w = 0; w < 64; w++)
        map_words[w] = '0;
      expected_rsps.delete();
      fail_cnt_o = 0;
    end else begin
      if (done_i) begin
        if (expected_rsps.size() == 0) begin
          report("result with no item outstanding");
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.status !== want.status)
            report($sformatf("status %0d, expected %0d", rsp_i.status, want.status));
          if (rsp_i.run_length !== want.run_length)
            report($sformatf("run_length %0d, expected %0d",
                             rsp_i.run_length, want.run_length));
          if (rsp_i.run_value !== want.run_value)
            report($sformatf("run_value %0b, expected %0b",
                             rsp_i.run_value, want.run_value));
        end
      end
      if (start_i && !busy_i) begin
        apply_item(req_i, res);
        expected_rsps.push_back(res);
      end
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap range engine testbench
// Directed corner items then random range tests, fills and run queries, with
// random gaps on the request side; results are checked by tb_checker.
// ----------------------------------------------------------------------------
module tb;
  import bre_pkg::*;

  localparam int unsigned RandItems = 1850;
  localparam int unsigned MaxCycles = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  req_t        req_i;
  logic        busy;
  logic        done_o;
  rsp_t        rsp_o;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned cycle_cnt;
  int unsigned fill_first;
  int unsigned fill_len;
  logic        fill_val;

  bitmap_range_engine_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  tb_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req_i),
    .done_i     (done_o),
    .rsp_i      (rsp_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("tb: errors");
      $finish;
    end
  end

  // present one item and hold it until taken; start is left high
  task automatic send(input kind_e k, input int unsigned first, input int unsigned len,
                      input logic val, input int unsigned lim);
    req_t r;
    r.kind        = k;
    r.start_index = 12'(first);
    r.length      = 13'(len);
    r.value       = val;
    r.limit_index = 13'(lim);
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // random item, mostly well-formed with small sizes
  task automatic send_random();
    int unsigned sel;
    int unsigned first;
    int unsigned len;
    int unsigned lim;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      // noise over the full field ranges
      send(kind_e'($urandom_range(0, 3)), $urandom_range(0, 4095),
           $urandom_range(0, 8191), 1'($urandom), $urandom_range(0, 8191));
    end else if (sel < 34) begin
      len   = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 150);
      first = $urandom_range(0, 4096 - len);
      fill_first = first;
      fill_len   = len;
      fill_val   = 1'($urandom);
      send(KIND_FILL, first, len, fill_val, $urandom_range(0, 8191));
    end else if (sel < 64) begin
      if ($urandom_range(0, 1)) begin
        // recheck the last fill, sometimes one bit wider
        len = fill_len + $urandom_range(0, 1);
        if (fill_first + len > 4096) len = fill_len;
        send(KIND_TEST, fill_first, len, fill_val, $urandom_range(0, 8191));
      end else begin
        len   = $urandom_range(1, 150);
        first = $urandom_range(0, 4096 - len);
        send(KIND_TEST, first, len, 1'($urandom), $urandom_range(0, 8191));
      end
    end else begin
      first = ($urandom_range(0, 1)) ? fill_first : $urandom_range(0, 4095);
      lim   = ($urandom_range(0, 9) == 0) ? 4096 : first + $urandom_range(1, 300);
      if (lim > 4096) lim = 4096;
      if (first >= lim) first = lim - 1;
      send(KIND_RUN, first, $urandom_range(0, 8191), 1'($urandom), lim);
    end
  endtask

  initial begin
    cycle_cnt  = 0;
    start      = 1'b0;
    req_i      = '0;
    fill_first = 0;
    fill_len   = 1;
    fill_val   = 1'b0;
    rst_ni     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    send(KIND_RUN,  0,    0,    1'b0, 4096);
    send(KIND_TEST, 0,    4096, 1'b0, 0);
    send(KIND_FILL, 0,    4096, 1'b1, 8191);
    send(KIND_TEST, 0,    4096, 1'b1, 0);
    send(KIND_RUN,  4095, 8191, 1'b1, 4096);
    send(KIND_FILL, 100,  37,   1'b0, 0);
    send(KIND_RUN,  0,    0,    1'b0, 4096);
    send(KIND_RUN,  100,  0,    1'b0, 4096);
    send(KIND_RUN,  120,  0,    1'b0, 130);
    send(KIND_TEST, 99,   2,    1'b0, 0);
    send(KIND_TEST, 100,  37,   1'b0, 0);
    send(KIND_BAD,  5,    5,    1'b1, 10);
    send(KIND_TEST, 3,    0,    1'b1, 0);
    send(KIND_FILL, 4095, 0,    1'b1, 0);
    send(KIND_FILL, 4095, 2,    1'b0, 0);
    send(KIND_TEST, 4095, 8191, 1'b0, 0);
    send(KIND_TEST, 4095, 1,    1'b1, 0);
    send(KIND_FILL, 4095, 1,    1'b0, 0);
    send(KIND_RUN,  10,   0,    1'b0, 10);
    send(KIND_RUN,  4095, 0,    1'b0, 4095);
    send(KIND_RUN,  0,    0,    1'b0, 4097);
    send(KIND_RUN,  4000, 0,    1'b0, 8191);
    send(KIND_FILL, 0,    4096, 1'b0, 0);
    send(KIND_RUN,  4095, 0,    1'b1, 4096);

    // random items; no gaps in the middle stretch
    for (int n = 0; n < RandItems; n++) begin
      if (n == RandItems / 2) begin
        start <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      send_random();
      if ((n < 600 || n > 900) && $urandom_range(0, 99) < 20)
        idle($urandom_range(1, 20));
    end
    start <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (150) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bre_pkg.sv
hdl/bre_front.sv
hdl/bre_queue.sv
hdl/bre_back.sv
hdl/bitmap_range_engine_core.sv
sim/tb_checker.sv
sim/tb.sv
